FILE: src/clb_pkg.sv
package clb_pkg;

  localparam int unsigned MaxSide  = 32;
  localparam int unsigned MaxPart  = 1024;
  localparam int unsigned NBins    = MaxSide * MaxSide;
  localparam int unsigned BinW     = $clog2(NBins);
  localparam int unsigned PidW     = $clog2(MaxPart);
  localparam int unsigned IdW      = PidW + 1;
  localparam int unsigned SideW    = 6;
  localparam int unsigned CellW    = $clog2(MaxSide);
  localparam int unsigned LenW     = 31;
  localparam int unsigned DivW     = 32;
  localparam int unsigned CfgW     = 31;
  localparam int unsigned CfgIdxW  = 1;

  localparam logic [IdW-1:0] NoneId = IdW'(MaxPart);

  typedef enum logic [1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_ASSIGN = 2'd1,
    ACT_QUERY  = 2'd2,
    ACT_UNUSED = 2'd3
  } act_e;

  localparam logic [CfgIdxW-1:0] CfgSide = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgLen  = 1'd1;

  typedef enum logic [3:0] {
    ST_INIT, ST_IDLE, ST_CLEAR, ST_DIV, ST_ASG_RD, ST_ASG_WR,
    ST_Q_RDP, ST_Q_START, ST_Q_DIV, ST_Q_RDB, ST_Q_CTR, ST_Q_SIDE,
    ST_Q_NBR, ST_Q_NBC, ST_DONE
  } state_e;

  typedef struct packed {
    logic [1:0]        action;
    logic [PidW-1:0]   particle_id;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
  } in_t;

  typedef struct packed {
    logic [BinW-1:0] bin_index;
    logic [IdW-1:0]  bin_size;
    logic [IdW-1:0]  own_next;
    logic [IdW-1:0]  vertical_head;
    logic [IdW-1:0]  horizontal_head;
    logic [IdW-1:0]  diagonal_head;
  } out_t;

  typedef struct packed {
    logic [IdW-1:0] head;
    logic [IdW-1:0] count;
  } bin_ent_t;

  typedef struct packed {
    logic [BinW-1:0] bin;
    logic [IdW-1:0]  next;
  } part_ent_t;

  function automatic out_t empty_res();
    out_t r;
    r.bin_index       = '0;
    r.bin_size        = '0;
    r.own_next        = NoneId;
    r.vertical_head   = NoneId;
    r.horizontal_head = NoneId;
    r.diagonal_head   = NoneId;
    return r;
  endfunction

endpackage

FILE: src/clb_div.sv
module clb_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [clb_pkg::DivW-1:0]  a0_i,
  input  logic [clb_pkg::DivW-1:0]  a1_i,
  input  logic [clb_pkg::LenW-1:0]  d_i,
  output logic                      done_o,
  output logic [clb_pkg::DivW-1:0]  q0_o,
  output logic [clb_pkg::DivW-1:0]  q1_o,
  output logic [clb_pkg::LenW-1:0]  r0_o
);
  import clb_pkg::*;

  localparam int unsigned CntW = $clog2(DivW);

  logic [DivW-1:0] quo0_q, quo1_q;
  logic [LenW-1:0] rem0_q, rem1_q, d_q;
  logic [CntW-1:0] cnt_q;
  logic            busy_q, done_q;
  logic [DivW-1:0] t0, t1;
  logic            ge0, ge1;

  // one restoring step per cycle on both lanes
  assign t0  = {rem0_q, quo0_q[DivW-1]};
  assign t1  = {rem1_q, quo1_q[DivW-1]};
  assign ge0 = t0 >= {1'b0, d_q};
  assign ge1 = t1 >= {1'b0, d_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(DivW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo0_q <= a0_i;
      quo1_q <= a1_i;
      rem0_q <= '0;
      rem1_q <= '0;
      d_q    <= d_i;
    end else if (busy_q) begin
      quo0_q <= {quo0_q[DivW-2:0], ge0};
      quo1_q <= {quo1_q[DivW-2:0], ge1};
      rem0_q <= ge0 ? LenW'(t0 - {1'b0, d_q}) : LenW'(t0);
      rem1_q <= ge1 ? LenW'(t1 - {1'b0, d_q}) : LenW'(t1);
    end
  end

  assign done_o = done_q;
  assign q0_o   = quo0_q;
  assign q1_o   = quo1_q;
  assign r0_o   = rem0_q;

endmodule

FILE: src/particle_cell_list_binning.sv
// Assign: a 32-step divide of the position by the cell length, then one bin read and write.
// Query: divide of the stored bin by the side, four reads of the bin memory.
// Clear: n*n bins written (n the side clamped to 1..32), one bin per cycle. Unused action: empty result.
// One word in flight; the next is taken while a result waits in the output register.
// After reset all 1024 bins of the bin memory are cleared before the first word is taken.
module particle_cell_list_binning (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  clb_pkg::in_t                  in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output clb_pkg::out_t                 out_data_o,
  input  logic                          cfg_we_i,
  input  logic [clb_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [clb_pkg::CfgW-1:0]      cfg_data_i
);
  import clb_pkg::*;

  localparam logic [1:0] NbVert = 2'd0;
  localparam logic [1:0] NbHorz = 2'd1;
  localparam logic [1:0] NbDiag = 2'd2;

  state_e state_q, state_d;

  logic [SideW-1:0] side_q;
  logic [LenW-1:0]  len_q;
  logic [SideW-1:0] n;
  logic [LenW-1:0]  len;
  logic [2*SideW-1:0] nn;

  bin_ent_t  bin_mem [NBins];
  part_ent_t part_mem [MaxPart];
  bin_ent_t  bin_rd_q;
  part_ent_t part_rd_q;

  logic            bin_we, part_we;
  logic [BinW-1:0] bin_wa, bin_ra;
  bin_ent_t        bin_wd;

  logic [BinW-1:0] cnt_q;
  in_t             item_q;
  out_t            res_q, out_q;
  logic            out_valid_q;
  logic [BinW-1:0] b_q;
  logic [CellW-1:0] cx_q, cy_q;
  logic            stale_q, sx_q, sy_q, nb_ok_q;
  logic [1:0]      k_q;
  logic [LenW+SideW-1:0] tcx_q, tcy_q;

  logic            div_start, div_done;
  logic [DivW-1:0] div_a0, div_a1, q0, q1;
  logic [LenW-1:0] div_d, r0;

  logic [CellW-1:0] cx_cl, cy_cl;
  logic signed [CellW+1:0] nx, ny;
  logic            nb_ok;
  logic [2*SideW-1:0] nb_addr;
  logic [IdW-1:0]  cnt_inc;

  assign n   = (side_q == '0) ? SideW'(1) :
               (side_q > SideW'(MaxSide)) ? SideW'(MaxSide) : side_q;
  assign len = (len_q == '0) ? LenW'(1) : len_q;
  assign nn  = n * n;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q <= SideW'(16);
      len_q  <= LenW'(4096);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgSide: side_q <= cfg_data_i[SideW-1:0];
        CfgLen:  len_q  <= cfg_data_i[LenW-1:0];
        default: ;
      endcase
    end
  end

  clb_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .a0_i   (div_a0),
    .a1_i   (div_a1),
    .d_i    (div_d),
    .done_o (div_done),
    .q0_o   (q0),
    .q1_o   (q1),
    .r0_o   (r0)
  );

  // negative coordinates land in cell zero
  always_comb begin
    div_a0 = '0;
    div_a1 = '0;
    div_d  = len;
    if (state_q == ST_Q_START) begin
      div_a0 = DivW'(part_rd_q.bin);
      div_d  = LenW'(n);
    end else begin
      div_a0 = in_data_i.pos_x[31] ? '0 : DivW'(in_data_i.pos_x);
      div_a1 = in_data_i.pos_y[31] ? '0 : DivW'(in_data_i.pos_y);
    end
  end

  assign cx_cl = (q0 > DivW'(n - 1'b1)) ? CellW'(n - 1'b1) : q0[CellW-1:0];
  assign cy_cl = (q1 > DivW'(n - 1'b1)) ? CellW'(n - 1'b1) : q1[CellW-1:0];

  // neighbour k: vertical (0,sy), horizontal (sx,0), diagonal (sx,sy)
  always_comb begin
    nx = $signed({2'b00, cx_q});
    ny = $signed({2'b00, cy_q});
    if (k_q != NbVert) nx = sx_q ? nx + (CellW+2)'(1) : nx - (CellW+2)'(1);
    if (k_q != NbHorz) ny = sy_q ? ny + (CellW+2)'(1) : ny - (CellW+2)'(1);
    nb_ok   = !nx[CellW+1] && !ny[CellW+1] &&
              (nx < $signed({1'b0, n})) && (ny < $signed({1'b0, n}));
    nb_addr = (2*SideW)'(ny[CellW-1:0]) * (2*SideW)'(n) + (2*SideW)'(nx[CellW-1:0]);
  end

  assign cnt_inc = (bin_rd_q.count < NoneId) ? bin_rd_q.count + 1'b1 : bin_rd_q.count;

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    div_start  = 1'b0;
    bin_we     = 1'b0;
    bin_wa     = cnt_q;
    bin_wd     = '{head: NoneId, count: '0};
    bin_ra     = b_q;
    part_we    = 1'b0;
    unique case (state_q)
      ST_INIT: begin
        bin_we = 1'b1;
        if (cnt_q == BinW'(NBins - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          unique case (act_e'(in_data_i.action))
            ACT_CLEAR:  state_d = ST_CLEAR;
            ACT_ASSIGN: begin
              div_start = 1'b1;
              state_d   = ST_DIV;
            end
            ACT_QUERY:  state_d = ST_Q_RDP;
            ACT_UNUSED: state_d = ST_DONE;
            default:    state_d = ST_DONE;
          endcase
        end
      end
      ST_CLEAR: begin
        bin_we = 1'b1;
        if (cnt_q == BinW'(nn - 1'b1)) state_d = ST_DONE;
      end
      ST_DIV:    if (div_done) state_d = ST_ASG_RD;
      ST_ASG_RD: state_d = ST_ASG_WR;
      ST_ASG_WR: begin
        bin_we  = 1'b1;
        bin_wa  = b_q;
        bin_wd  = '{head: IdW'(item_q.particle_id), count: cnt_inc};
        part_we = 1'b1;
        state_d = ST_DONE;
      end
      ST_Q_RDP:   state_d = ST_Q_START;
      ST_Q_START: begin
        div_start = 1'b1;
        state_d   = ST_Q_DIV;
      end
      ST_Q_DIV:  if (div_done) state_d = ST_Q_RDB;
      ST_Q_RDB:  state_d = ST_Q_CTR;
      ST_Q_CTR:  state_d = ST_Q_SIDE;
      ST_Q_SIDE: state_d = ST_Q_NBR;
      ST_Q_NBR: begin
        bin_ra  = nb_addr[BinW-1:0];
        state_d = ST_Q_NBC;
      end
      ST_Q_NBC: state_d = (k_q == NbDiag) ? ST_DONE : ST_Q_NBR;
      ST_DONE:  if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_INIT || state_q == ST_CLEAR) cnt_q <= cnt_q + 1'b1;
      else cnt_q <= '0;
      if (state_q == ST_DONE && state_d == ST_IDLE) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (bin_we) bin_mem[bin_wa] <= bin_wd;
    bin_rd_q <= bin_mem[bin_ra];
    if (part_we) part_mem[item_q.particle_id] <= '{bin: b_q, next: bin_rd_q.head};
    part_rd_q <= part_mem[item_q.particle_id];
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        item_q <= in_data_i;
        res_q  <= empty_res();
        k_q    <= NbVert;
      end
      ST_DIV: if (div_done) begin
        b_q <= BinW'((2*SideW)'(cy_cl) * (2*SideW)'(n) + (2*SideW)'(cx_cl));
      end
      ST_ASG_WR: begin
        res_q.bin_index <= b_q;
        res_q.bin_size  <= cnt_inc;
        res_q.own_next  <= bin_rd_q.head;
      end
      ST_Q_START: begin
        b_q            <= part_rd_q.bin;
        res_q.own_next <= part_rd_q.next;
        res_q.bin_index <= part_rd_q.bin;
      end
      ST_Q_DIV: if (div_done) begin
        cx_q    <= r0[CellW-1:0];
        cy_q    <= q0[CellW-1:0];
        stale_q <= q0 >= DivW'(n);
      end
      ST_Q_CTR: begin
        res_q.bin_size <= bin_rd_q.count;
        tcx_q <= len * (LenW+SideW)'({cx_q, 1'b1});
        tcy_q <= len * (LenW+SideW)'({cy_q, 1'b1});
      end
      ST_Q_SIDE: begin
        sx_q <= $signed({{5{item_q.pos_x[31]}}, item_q.pos_x, 1'b0}) >= $signed({1'b0, tcx_q});
        sy_q <= $signed({{5{item_q.pos_y[31]}}, item_q.pos_y, 1'b0}) >= $signed({1'b0, tcy_q});
      end
      ST_Q_NBR: nb_ok_q <= nb_ok && !stale_q;
      ST_Q_NBC: begin
        k_q <= k_q + 1'b1;
        unique case (k_q)
          NbVert:  res_q.vertical_head   <= nb_ok_q ? bin_rd_q.head : NoneId;
          NbHorz:  res_q.horizontal_head <= nb_ok_q ? bin_rd_q.head : NoneId;
          default: res_q.diagonal_head   <= nb_ok_q ? bin_rd_q.head : NoneId;
        endcase
      end
      ST_DONE: if (!out_valid_q || out_ready_i) out_q <= res_q;
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: src/clb_checker.sv
module clb_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_ready_o,
  input  clb_pkg::in_t                in_data_i,
  input  logic                        out_valid_o,
  input  logic                        out_ready_i,
  input  clb_pkg::out_t               out_data_o
);
  import clb_pkg::*;

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result word changed while stalled");

  // one word in flight
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second word taken while busy");

  a_clear_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_data_i.action == ACT_CLEAR |=> !out_valid_o ||
    $past(out_valid_o) && !$past(out_ready_i))
    else $error("result before clear finished");

  a_ids: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.bin_size <= NoneId && out_data_o.own_next <= NoneId &&
    out_data_o.vertical_head <= NoneId && out_data_o.horizontal_head <= NoneId &&
    out_data_o.diagonal_head <= NoneId)
    else $error("particle id out of range");

endmodule

bind particle_cell_list_binning clb_checker u_clb_checker (.*);
